[rtl/ghbs_pkg.sv]
// ----------------------------------------------------------------------------
// ghbs_pkg: shared types and constants of the gray histogram block
// Operation codes, register map, field widths and the scaler state type.
// ----------------------------------------------------------------------------
package ghbs_pkg;

  // Widths of the fixed item fields.
  localparam int OP_W    = 2;
  localparam int LEVEL_W = 8;
  localparam int BAR_W   = 10;

  // Number of bits needed to count the divider steps (one quotient bit each).
  localparam int STEP_W = $clog2(BAR_W);

  // Configuration port: word-addressed registers, 32-bit data.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Word index (address bit 2) of the bar height register.
  localparam logic REG_BAR_HEIGHT = 1'b0;

  // Value of the bar height register after reset.
  localparam logic [BAR_W-1:0] BAR_HEIGHT_RST = BAR_W'(230);

  // Item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Bar scaler sequencer states.
  typedef enum logic [2:0] {
    SCL_IDLE,
    SCL_MUL,
    SCL_DIV,
    SCL_ROUND,
    SCL_DONE
  } scl_state_e;

endpackage

[rtl/ghbs_scale.sv]
// ----------------------------------------------------------------------------
// ghbs_scale: bar height scaler
// Computes count * bar_height / peak rounded to nearest, ties to even, with
// a multiply step, a restoring divider that yields one quotient bit per
// cycle, and a rounding step. The result is held until it is taken.
// ----------------------------------------------------------------------------
module ghbs_scale #(
  parameter int COUNT_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [COUNT_BITS-1:0]       count_i,
  input  logic [COUNT_BITS-1:0]       peak_i,
  input  logic [ghbs_pkg::BAR_W-1:0]  bar_height_i,
  input  logic                        take_i,
  output logic                        done_o,
  output logic [COUNT_BITS-1:0]       count_o,
  output logic [ghbs_pkg::BAR_W-1:0]  bar_o,
  output logic [COUNT_BITS-1:0]       peak_o
);
  import ghbs_pkg::*;

  localparam int PROD_W = COUNT_BITS + BAR_W;

  scl_state_e                state_q, state_d;
  logic [STEP_W-1:0]         step_q;
  logic                      last_step;

  logic [COUNT_BITS-1:0]     cnt_q;
  logic [COUNT_BITS-1:0]     pk_q;
  logic [BAR_W-1:0]          bh_q;
  logic                      zero_q;
  logic [PROD_W-1:0]         prod;
  logic [COUNT_BITS-1:0]     rem_q;
  logic [BAR_W-1:0]          low_q;
  logic [BAR_W-1:0]          quo_q;
  logic [BAR_W-1:0]          bar_q;

  logic [COUNT_BITS:0]       trial;
  logic [COUNT_BITS:0]       pk_ext;
  logic [COUNT_BITS:0]       diff;
  logic                      qbit;
  logic [COUNT_BITS-1:0]     rem_n;
  logic [COUNT_BITS:0]       twice_rem;
  logic                      round_up;

  assign last_step = (step_q == STEP_W'(BAR_W - 1));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SCL_IDLE:  if (start_i) state_d = SCL_MUL;
      SCL_MUL:   state_d = SCL_DIV;
      SCL_DIV:   if (last_step) state_d = SCL_ROUND;
      SCL_ROUND: state_d = SCL_DONE;
      SCL_DONE:  if (take_i) state_d = SCL_IDLE;
      default:   state_d = SCL_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    case (state_q)
      SCL_DONE: done_o = 1'b1;
      default:  done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCL_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SCL_DIV) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
      end
    end
  end

  // The quotient never exceeds bar_height because count never exceeds peak,
  // so the upper part of the product is already below the divisor and only
  // BAR_W quotient bits have to be developed.
  assign prod = PROD_W'(cnt_q) * PROD_W'(bh_q);

  // One restoring division step.
  assign trial  = {rem_q, low_q[BAR_W-1]};
  assign pk_ext = {1'b0, pk_q};
  assign diff   = trial - pk_ext;
  assign qbit   = (trial >= pk_ext);
  assign rem_n  = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

  // Round to nearest, ties to even.
  assign twice_rem = {rem_q, 1'b0};
  assign round_up  = (twice_rem > pk_ext) || ((twice_rem == pk_ext) && quo_q[0]);

  // Operand capture and datapath.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SCL_IDLE)) begin
      cnt_q  <= count_i;
      pk_q   <= peak_i;
      bh_q   <= bar_height_i;
      zero_q <= (peak_i == '0) || (bar_height_i == '0);
    end
    case (state_q)
      SCL_MUL: begin
        rem_q <= prod[PROD_W-1:BAR_W];
        low_q <= prod[BAR_W-1:0];
        quo_q <= '0;
      end
      SCL_DIV: begin
        rem_q <= rem_n;
        low_q <= {low_q[BAR_W-2:0], 1'b0};
        quo_q <= {quo_q[BAR_W-2:0], qbit};
      end
      SCL_ROUND: begin
        bar_q <= zero_q ? '0 : quo_q + BAR_W'(round_up);
      end
      default: ;
    endcase
  end

  assign count_o = cnt_q;
  assign peak_o  = pk_q;
  assign bar_o   = bar_q;

endmodule

[rtl/gray_histogram_with_bar_scaling.sv]
// ----------------------------------------------------------------------------
// gray_histogram_with_bar_scaling: 8-bit gray level histogram
// Counts pixels into saturating bins held in one synchronous memory, tracks
// the peak bin and scales a bin's count to a bar height on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, op_i, level_i) carries items:
//   accumulate a pixel, read a bin, or clear the histogram. Only a read
//   produces a result item on the output channel (out_valid_o / out_stall_i,
//   count_o, bar_o, peak_o).
//   Accumulates are taken one per cycle while no read, clear or sweep holds
//   the input. Each one reads its bin from the memory, increments it in the
//   next cycle and writes it back; a write to the bin that the following
//   item reads is forwarded around the memory. A read blocks the input until
//   its result is in the output register: the result passes through the
//   memory read, the multiply step, ten divider steps (one quotient bit
//   each), rounding and the load of the output register.
//   A clear stalls the input while a sweep writes zero to every bin, one bin
//   per cycle; the next item is taken after the sweep's last write.
//   After reset the same sweep runs before the first item is taken;
//   configuration writes are taken at any time.
//   While the receiver stalls, the result is held in the output register and
//   accumulates keep flowing; a further read waits in the scaler.
//   bar_height lies at byte address 0 of the configuration port.
// ----------------------------------------------------------------------------
module gray_histogram_with_bar_scaling #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ghbs_pkg::OP_W-1:0]     op_i,
  input  logic [ghbs_pkg::LEVEL_W-1:0]  level_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COUNT_BITS-1:0]         count_o,
  output logic [ghbs_pkg::BAR_W-1:0]    bar_o,
  output logic [COUNT_BITS-1:0]         peak_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ghbs_pkg::PADDR_W-1:0]  paddr,
  input  logic [ghbs_pkg::PDATA_W-1:0]  pwdata,
  output logic [ghbs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ghbs_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_LIMIT = '1;

  // Configuration register.
  logic [BAR_W-1:0]        bar_height_q;
  logic                    cfg_wr;

  // Input acceptance and item sequencing.
  logic                    in_acc;
  logic                    busy_q, busy_d;
  logic                    is_read, is_clear;

  // Histogram memory.
  logic [COUNT_BITS-1:0]   mem_q [BINS];
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [COUNT_BITS-1:0]   rdata_q;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;
  logic                    fwd_hit_q;
  logic [COUNT_BITS-1:0]   fwd_data_q;

  // Second stage: the item whose bin was read in the previous cycle.
  logic                    s1_valid_q;
  logic [OP_W-1:0]         s1_op_q;
  logic                    s1_inr_q;
  logic [AW-1:0]           s1_addr_q;
  logic [COUNT_BITS-1:0]   cur;
  logic [COUNT_BITS-1:0]   inc;
  logic                    s1_acc, s1_read, s1_clear;

  // Clearing sweep and peak.
  logic                    sweep_q;
  logic [AW-1:0]           sweep_addr_q;
  logic                    sweep_last;
  logic [COUNT_BITS-1:0]   peak_q, peak_d;

  // Scaler and output register.
  logic                    scl_done;
  logic                    scl_take;
  logic [COUNT_BITS-1:0]   scl_count;
  logic [BAR_W-1:0]        scl_bar;
  logic [COUNT_BITS-1:0]   scl_peak;
  logic                    out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0]   count_q;
  logic [BAR_W-1:0]        bar_q;
  logic [COUNT_BITS-1:0]   opeak_q;

  // Configuration port: register at word index zero, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BAR_HEIGHT);
  assign prdata = (paddr[2] == REG_BAR_HEIGHT) ? PDATA_W'(bar_height_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_height_q <= BAR_HEIGHT_RST;
    end else if (cfg_wr) begin
      bar_height_q <= pwdata[BAR_W-1:0];
    end
  end

  // Reads and clears hold the input until they have finished.
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign is_read    = (op_i == OP_READ);
  assign is_clear   = (op_i == OP_CLEAR);

  // Stage one decode.
  assign s1_acc   = s1_valid_q && (s1_op_q == OP_ACC) && s1_inr_q;
  assign s1_read  = s1_valid_q && (s1_op_q == OP_READ);
  assign s1_clear = s1_valid_q && (s1_op_q == OP_CLEAR);

  // Bin value seen by stage one, with the write of the previous cycle forwarded.
  assign cur = fwd_hit_q ? fwd_data_q : rdata_q;
  assign inc = (cur == CNT_LIMIT) ? cur : cur + 1'b1;

  // Memory access control.
  assign rd_en      = in_acc;
  assign rd_addr    = AW'(level_i);
  assign sweep_last = (sweep_addr_q == AW'(BINS - 1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_addr_q;
    wr_data = inc;
    if (sweep_q) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr_q;
      wr_data = '0;
    end else if (s1_acc) begin
      wr_en = 1'b1;
    end
  end

  // Histogram memory: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Forwarding register for a read that meets a write to the same bin.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
  end

  // Stage one item registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= op_i;
      s1_inr_q  <= (32'(level_i) < BINS);
      s1_addr_q <= rd_addr;
    end
  end

  // Peak tracking: reset by a clear, raised by a larger bin value.
  always_comb begin
    peak_d = peak_q;
    if (s1_clear) begin
      peak_d = '0;
    end else if (s1_acc && (inc > peak_q)) begin
      peak_d = inc;
    end
  end

  // Busy flag: set by an accepted read or clear, released when it is done.
  always_comb begin
    busy_d = busy_q;
    if (in_acc && (is_read || is_clear)) begin
      busy_d = 1'b1;
    end else if (scl_take || (sweep_q && sweep_last)) begin
      busy_d = 1'b0;
    end
  end

  // Clearing sweep, run after reset and after every clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      busy_q       <= 1'b1;
      peak_q       <= '0;
    end else begin
      busy_q <= busy_d;
      peak_q <= peak_d;
      if (s1_clear) begin
        sweep_q      <= 1'b1;
        sweep_addr_q <= '0;
      end else if (sweep_q) begin
        sweep_q      <= !sweep_last;
        sweep_addr_q <= sweep_last ? '0 : sweep_addr_q + 1'b1;
      end
    end
  end

  // Bar scaler.
  ghbs_scale #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ghbs_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s1_read),
    .count_i      (s1_inr_q ? cur : '0),
    .peak_i       (peak_q),
    .bar_height_i (bar_height_q),
    .take_i       (scl_take),
    .done_o       (scl_done),
    .count_o      (scl_count),
    .bar_o        (scl_bar),
    .peak_o       (scl_peak)
  );

  // Output register: filled from the scaler whenever it is free.
  assign scl_take = scl_done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (scl_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scl_take) begin
      count_q <= scl_count;
      bar_q   <= scl_bar;
      opeak_q <= scl_peak;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign bar_o       = bar_q;
  assign peak_o      = opeak_q;

endmodule

[rtl/ghbs_checker.sv]
// ----------------------------------------------------------------------------
// ghbs_checker: port-level checks of the gray histogram block
// Watches the item channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module ghbs_checker #(
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [ghbs_pkg::OP_W-1:0]     op_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [COUNT_BITS-1:0]         count_o,
  input  logic [ghbs_pkg::BAR_W-1:0]    bar_o,
  input  logic [COUNT_BITS-1:0]         peak_o
);
  import ghbs_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(count_o) && $stable(bar_o) && $stable(peak_o))
    else $error("result item changed while stalled");

  // No bin can hold more than the peak.
  a_count_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= peak_o)
    else $error("bin count above peak");

  // An empty histogram gives an empty bar and an empty bin.
  a_zero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (peak_o == '0) |-> (bar_o == '0) && (count_o == '0))
    else $error("nonzero bar or count with zero peak");

  // A clear holds off the next item while the bins are swept.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_CLEAR) |=> in_stall_o)
    else $error("item taken during clearing sweep");

endmodule

bind gray_histogram_with_bar_scaling ghbs_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_ghbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .count_o     (count_o),
  .bar_o       (bar_o),
  .peak_o      (peak_o)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gray level histogram with bar scaling
// Streams accumulate, read, clear and unused-code items through the input
// channel, predicts every bin read with an internal histogram copy and checks
// count, bar and peak of each result item in order. It covers several bar
// height settings, a back-to-back pixel stream, and random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ghbs_pkg::*;

  localparam int CNT_W = 20;
  localparam int BIN_NUM = 256;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // Longest quiet time of the block after its last result (clear sweep).
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS = 260;
  localparam int STREAM_ITEMS = 60;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] level;
  } hist_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [BAR_W-1:0] bar;
    logic [CNT_W-1:0] peak;
  } bin_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] op_i = '0;
  logic [LEVEL_W-1:0] level_i = '0;

  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CNT_W-1:0] count_o;
  logic [BAR_W-1:0] bar_o;
  logic [CNT_W-1:0] peak_o;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Histogram copy kept in step with the accepted items.
  logic [CNT_W-1:0] hist_bins [BIN_NUM];
  logic [CNT_W-1:0] peak_bin;
  logic [BAR_W-1:0] bar_height_cfg = BAR_HEIGHT_RST;

  hist_item_t pixel_items_q[$];
  bin_read_t bin_reads_q[$];
  int mismatches = 0;

  int burst_left = 1;
  int gap_left = 0;
  bit free_run = 1'b0;
  int open_left = 0;
  int stall_left = 0;

  gray_histogram_with_bar_scaling u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .count_o     (count_o),
    .bar_o       (bar_o),
    .peak_o      (peak_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // Bar height is count * height / peak, rounded to nearest, ties to even.
  function automatic logic [BAR_W-1:0] scaled_bar(input logic [CNT_W-1:0] cnt,
                                                  input logic [CNT_W-1:0] pk,
                                                  input logic [BAR_W-1:0] bh);
    logic [CNT_W+BAR_W-1:0] prod;
    logic [CNT_W+BAR_W-1:0] quo;
    logic [CNT_W+BAR_W-1:0] rem;
    if (pk == '0 || bh == '0) return '0;
    prod = cnt * bh;
    quo = prod / pk;
    rem = prod % pk;
    if ({rem, 1'b0} > pk || ({rem, 1'b0} == pk && quo[0])) quo = quo + 1'b1;
    return quo[BAR_W-1:0];
  endfunction

  // Update the histogram copy with one accepted item; reads queue a result.
  function automatic void apply_histogram_item(input hist_item_t it);
    bin_read_t res;
    case (it.op)
      OP_ACC: begin
        if (hist_bins[it.level] != CNT_MAX) hist_bins[it.level] = hist_bins[it.level] + 1'b1;
        if (hist_bins[it.level] > peak_bin) peak_bin = hist_bins[it.level];
      end
      OP_READ: begin
        res.count = hist_bins[it.level];
        res.bar = scaled_bar(hist_bins[it.level], peak_bin, bar_height_cfg);
        res.peak = peak_bin;
        bin_reads_q.push_back(res);
      end
      OP_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        peak_bin = '0;
      end
      default: ;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin : drive_items
    hist_item_t nxt_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_histogram_item('{op: op_i, level: level_i});
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (pixel_items_q.size() != 0) begin
          nxt_item = pixel_items_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= nxt_item.op;
          level_i <= nxt_item.level;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = (free_run || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: open stretches, some long, between stall runs.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (open_left > 0) begin
        open_left--;
      end else begin
        open_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 15);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Compare every accepted result item with the oldest predicted bin read.
  always @(posedge clk_i) begin : check_reads
    bin_read_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bin_reads_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got count %0d bar %0d peak %0d",
                 $time, count_o, bar_o, peak_o);
      end else begin
        want = bin_reads_q.pop_front();
        if (count_o !== want.count || bar_o !== want.bar || peak_o !== want.peak) begin
          mismatches++;
          $display("%0t: bin read: expected count %0d bar %0d peak %0d, got %0d %0d %0d",
                   $time, want.count, want.bar, want.peak, count_o, bar_o, peak_o);
        end
      end
    end
  end

  // Hand one item to the sender, keeping the backlog short.
  task automatic queue_item(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] level);
    while (pixel_items_q.size() >= 64) @(posedge clk_i);
    pixel_items_q.push_back('{op: op, level: level});
  endtask

  // Wait until every item is taken and every bin read has come back.
  task automatic wait_idle();
    while (pixel_items_q.size() != 0 || in_valid_i || bin_reads_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Configuration write: setup cycle, then access until pready.
  task automatic write_bar_height(input logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({REG_BAR_HEIGHT, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bar_height_cfg = value[BAR_W-1:0];
  endtask

  // Random traffic: mostly pixels, often on a few hot levels, plus reads, clears and unused codes.
  task automatic run_random_items(input int n);
    logic [LEVEL_W-1:0] hot [8];
    logic [LEVEL_W-1:0] lvl;
    int pick;
    foreach (hot[i]) hot[i] = LEVEL_W'($urandom_range(0, 255));
    for (int k = 0; k < n; k++) begin
      lvl = $urandom_range(0, 1) ? hot[$urandom_range(0, 7)] : LEVEL_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 70) queue_item(OP_ACC, lvl);
      else if (pick < 95) queue_item(OP_READ, lvl);
      else if (pick < 97) queue_item(OP_CLEAR, lvl);
      else queue_item(OP_SPARE, lvl);
    end
  endtask

  initial begin : stimulus
    logic [LEVEL_W-1:0] sat_lvl;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    peak_bin = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, extremes, unused code, rounding ties, clear.
    queue_item(OP_READ, 8'h00);
    queue_item(OP_ACC, 8'hFF);
    queue_item(OP_ACC, 8'hFF);
    queue_item(OP_ACC, 8'h00);
    queue_item(OP_ACC, 8'hAA);
    queue_item(OP_ACC, 8'h55);
    queue_item(OP_READ, 8'hFF);
    queue_item(OP_READ, 8'h00);
    queue_item(OP_READ, 8'h80);
    queue_item(OP_SPARE, 8'hFF);
    queue_item(OP_SPARE, 8'h00);
    queue_item(OP_ACC, 8'hFF);
    queue_item(OP_ACC, 8'hFF);
    // One of four at height 230 is a tie with odd quotient, rounds up.
    queue_item(OP_READ, 8'h00);
    queue_item(OP_ACC, 8'h00);
    queue_item(OP_ACC, 8'h00);
    // Three of four is a tie with even quotient, stays.
    queue_item(OP_READ, 8'h00);
    queue_item(OP_CLEAR, 8'h5A);
    queue_item(OP_READ, 8'hFF);
    queue_item(OP_ACC, 8'h0F);
    queue_item(OP_READ, 8'h0F);
    wait_idle();
    run_random_items(RANDOM_ITEMS);
    wait_idle();

    // Back-to-back pixel stream into one bin at full height.
    write_bar_height(32'd1023);
    free_run = 1'b1;
    sat_lvl = LEVEL_W'($urandom_range(0, 255));
    queue_item(OP_CLEAR, 8'h00);
    queue_item(OP_ACC, ~sat_lvl);
    queue_item(OP_ACC, ~sat_lvl);
    for (int k = 0; k < STREAM_ITEMS; k++) queue_item(OP_ACC, sat_lvl);
    queue_item(OP_ACC, ~sat_lvl);
    queue_item(OP_READ, sat_lvl);
    queue_item(OP_READ, ~sat_lvl);
    queue_item(OP_READ, sat_lvl + 8'd1);
    wait_idle();
    free_run = 1'b0;
    run_random_items(RANDOM_ITEMS);
    wait_idle();

    // Smallest height, out-of-range zero, upper data bits set, random ones.
    write_bar_height(32'd1);
    run_random_items(RANDOM_ITEMS);
    wait_idle();
    write_bar_height(32'd0);
    run_random_items(RANDOM_ITEMS);
    wait_idle();
    write_bar_height(32'hFFFF_FC64);
    run_random_items(RANDOM_ITEMS);
    wait_idle();
    write_bar_height(PDATA_W'($urandom_range(1, 1023)));
    run_random_items(RANDOM_ITEMS);
    wait_idle();
    write_bar_height(PDATA_W'($urandom_range(1, 1023)));
    run_random_items(RANDOM_ITEMS);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
